// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps

package swm_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int WSIZE_W  = 7;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// register index, taken from paddr[2]
	localparam logic REG_WINDOW_SIZE = 1'b0;

	// what one cell shows its neighbours
	typedef struct packed {
		logic                       ge;    // holds a value at or above the leaving sample
		logic                       up;    // moves one place towards the top end
		logic                       down;  // moves one place towards the bottom end
		logic signed [SAMPLE_W-1:0] value;
	} swm_link_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                       load;
		logic                       full;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] leaving;
	} swm_bcast_t;

endpackage

// ===== rtl/swm_cell.sv =====
`timescale 1ns / 1ps

module swm_cell (
	input  logic              clk,
	input  swm_pkg::swm_bcast_t bcast,
	input  logic              valid,
	input  swm_pkg::swm_link_t  left,
	input  swm_pkg::swm_link_t  right,
	output swm_pkg::swm_link_t  link
);
	import swm_pkg::*;

	logic signed [SAMPLE_W-1:0] value_q;
	logic gt;
	logic ge;
	logic gone_before;
	logic gone;
	logic keep;
	logic up;
	logic down;

	// where this cell's value goes when the window moves on
	always_comb begin
		gt          = valid && (value_q > bcast.sample);
		ge          = valid && (value_q >= bcast.leaving);
		gone_before = bcast.full && left.ge;
		gone        = bcast.full && valid && (value_q == bcast.leaving) && !gone_before;
		keep        = valid && !gone && (gone_before == gt);
		up          = valid && !gone && gt && !gone_before;
		down        = valid && !gone && gone_before && !gt;
	end

	assign link = '{ge: ge, up: up, down: down, value: value_q};

	// take from a neighbour, keep, or take the new sample
	always_ff @(posedge clk) begin
		if (bcast.load) begin
			if (right.down) begin
				value_q <= right.value;
			end else if (left.up) begin
				value_q <= left.value;
			end else if (keep) begin
				value_q <= value_q;
			end else begin
				value_q <= bcast.sample;
			end
		end
	end

endmodule

// ===== rtl/sliding_window_median.sv =====
`timescale 1ns / 1ps

// channel   signals                                   request
// input     in_valid, in_ready, sample, restart       one sample, optional restart
// output    out_valid, out_ready, median_doubled      twice the window median
// config    psel, penable, pwrite, paddr, pwdata,     window_size at address 0
//           prdata, pready
//
// one sample is taken per clock while in_ready is high; its result is held in the sorted
// cell row, then passes through the median select stage into the output register.
// the leaving sample is prefetched from the ring memory through its registered read port.
// reset empties the window and sets window_size to 3; no clearing pass is needed.
// a stalled result holds in_ready low only while a second result waits behind it.

module sliding_window_median #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                  restart,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [swm_pkg::MEDIAN_W-1:0]   median_doubled,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [swm_pkg::PADDR_W-1:0]           paddr,
	input  logic [swm_pkg::PDATA_W-1:0]           pwdata,
	output logic [swm_pkg::PDATA_W-1:0]           prdata,
	output logic                                  pready
);
	import swm_pkg::*;

	localparam int CW   = $clog2(WINDOW_MAX);
	localparam int KW   = $clog2(WINDOW_MAX + 1);
	localparam int CMPW = (KW > WSIZE_W) ? KW : WSIZE_W;

	logic [WSIZE_W-1:0] window_size_q;
	logic [KW-1:0]      fill_q;
	logic [CW-1:0]      oldest_q;
	logic               pend_s1_q;
	logic               out_valid_q;
	logic signed [MEDIAN_W-1:0] median_q;
	logic signed [SAMPLE_W-1:0] window_ring_q [WINDOW_MAX];
	logic signed [SAMPLE_W-1:0] leaving_q;

	logic [KW-1:0]  k;
	logic           cfg_write;
	logic           accept;
	logic           out_free;
	logic [KW-1:0]  fill_eff;
	logic [CW-1:0]  oldest_eff;
	logic           full;
	logic [KW-1:0]  fill_next;
	logic           result;
	logic [CW-1:0]  wr_slot;
	logic [CW-1:0]  oldest_next;
	logic [KW-1:0]  half;
	logic [CW-1:0]  hi_idx;
	logic [CW-1:0]  lo_idx;
	logic signed [SAMPLE_W-1:0] hi_val;
	logic signed [SAMPLE_W-1:0] lo_val;
	logic signed [MEDIAN_W-1:0] median_sum;
	logic [WINDOW_MAX-1:0] cell_valid;
	swm_bcast_t bcast;
	swm_link_t  link [WINDOW_MAX];

	// register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ?
		PDATA_W'(window_size_q) : '0;

	// effective window length
	always_comb begin
		if (window_size_q == '0) begin
			k = KW'(1);
		end else if (CMPW'(window_size_q) > CMPW'(WINDOW_MAX)) begin
			k = KW'(WINDOW_MAX);
		end else begin
			k = KW'(window_size_q);
		end
	end

	// handshake
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !pend_s1_q || out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign median_doubled = median_q;

	// window bookkeeping for the request at the port
	always_comb begin
		fill_eff   = restart ? '0 : fill_q;
		oldest_eff = restart ? '0 : oldest_q;
		full       = (fill_eff == k);
		fill_next  = full ? k : fill_eff + KW'(1);
		result     = (fill_next == k);
		if (full) begin
			wr_slot = oldest_eff;
			oldest_next = ((KW'(oldest_eff) + KW'(1)) == k) ? '0 : oldest_eff + CW'(1);
		end else begin
			wr_slot     = fill_eff[CW-1:0];
			oldest_next = oldest_eff;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WSIZE_W'(3);
			fill_q        <= '0;
			oldest_q      <= '0;
			pend_s1_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write && (paddr[2] == REG_WINDOW_SIZE)) begin
				window_size_q <= pwdata[WSIZE_W-1:0];
				fill_q        <= '0;
				oldest_q      <= '0;
			end else if (accept) begin
				fill_q   <= fill_next;
				oldest_q <= oldest_next;
			end
			if (accept) begin
				pend_s1_q <= result;
			end else if (out_free) begin
				pend_s1_q <= 1'b0;
			end
			if (pend_s1_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ring memory, with the next leaving sample read ahead
	always_ff @(posedge clk) begin
		if (accept) begin
			window_ring_q[wr_slot] <= sample;
			leaving_q <= (oldest_next == wr_slot) ? sample : window_ring_q[oldest_next];
		end
	end

	// sorted cell row
	assign bcast = '{load: accept, full: full, sample: sample, leaving: leaving_q};

	always_comb begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			cell_valid[i] = fill_eff > KW'(i);
		end
	end

	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
		swm_link_t left_link;
		swm_link_t right_link;
		if (g == 0) begin : g_first
			assign left_link = '0;
		end else begin : g_mid_l
			assign left_link = link[g-1];
		end
		if (g == WINDOW_MAX - 1) begin : g_last
			assign right_link = '0;
		end else begin : g_mid_r
			assign right_link = link[g+1];
		end
		swm_cell u_cell (
			.clk   (clk),
			.bcast (bcast),
			.valid (cell_valid[g]),
			.left  (left_link),
			.right (right_link),
			.link  (link[g])
		);
	end

	// median taps, fixed by the window length
	always_comb begin
		half   = k >> 1;
		hi_idx = half[CW-1:0];
		lo_idx = k[0] ? hi_idx : hi_idx - CW'(1);
		hi_val = '0;
		lo_val = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (CW'(i) == hi_idx) begin
				hi_val = hi_val | link[i].value;
			end
			if (CW'(i) == lo_idx) begin
				lo_val = lo_val | link[i].value;
			end
		end
		median_sum = {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};
	end

	// output register
	always_ff @(posedge clk) begin
		if (pend_s1_q && out_free) begin
			median_q <= median_sum;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k)
		else $error("window fill beyond its length");

	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		KW'(oldest_q) < k)
		else $error("oldest slot outside the window");

	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full) |=> (fill_q == $past(k)))
		else $error("full window lost or gained a sample");

	a_result_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && result) |=> pend_s1_q)
		else $error("result of a full window was dropped");

	a_pend_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1_q && out_free) |=> out_valid_q)
		else $error("pending median not loaded into the output register");

endmodule

// ===== tb/tb_sliding_window_median.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_median;

	import swm_pkg::*;

	localparam int WINDOW_MAX = 64;

	// register index beyond the map, a write to it must be dropped
	localparam logic REG_UNMAPPED = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [MEDIAN_W-1:0] M_MIN = 33'sh1_0000_0000;
	localparam logic signed [MEDIAN_W-1:0] M_MAX = 33'sh0_FFFF_FFFE;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       rs;
		logic                       pinned;
		logic                       has_res;
		logic signed [MEDIAN_W-1:0] res;
	} opening_row_t;

	// opening sequence at the reset window of 3
	localparam opening_row_t OPENING [21] = '{
		'{S_MIN,          1'b0, 1'b1, 1'b0, 33'sd0},
		'{S_MAX,          1'b0, 1'b1, 1'b0, 33'sd0},
		'{32'sd0,         1'b0, 1'b1, 1'b1, 33'sd0},
		'{S_MAX,          1'b0, 1'b1, 1'b1, M_MAX},
		'{S_MAX,          1'b0, 1'b1, 1'b1, M_MAX},
		'{S_MIN,          1'b1, 1'b1, 1'b0, 33'sd0},
		'{S_MIN,          1'b0, 1'b1, 1'b0, 33'sd0},
		'{S_MIN,          1'b0, 1'b1, 1'b1, M_MIN},
		'{32'sd5,         1'b0, 1'b1, 1'b1, M_MIN},
		'{32'sd5,         1'b0, 1'b1, 1'b1, 33'sd10},
		'{-32'sd1,        1'b0, 1'b1, 1'b1, 33'sd10},
		'{-32'sd7,        1'b0, 1'b1, 1'b1, -33'sd2},
		'{32'sd100,       1'b1, 1'b1, 1'b0, 33'sd0},
		'{-32'sd100,      1'b0, 1'b1, 1'b0, 33'sd0},
		'{32'sd3,         1'b0, 1'b1, 1'b1, 33'sd6},
		'{32'shAAAA_AAAA, 1'b0, 1'b0, 1'b0, 33'sd0},
		'{32'sh5555_5555, 1'b0, 1'b0, 1'b0, 33'sd0},
		'{-32'sd1,        1'b1, 1'b0, 1'b0, 33'sd0},
		'{32'sd0,         1'b0, 1'b0, 1'b0, 33'sd0},
		'{32'sd1,         1'b0, 1'b0, 1'b0, 33'sd0},
		'{S_MAX,          1'b0, 1'b0, 1'b0, 33'sd0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       restart = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [MEDIAN_W-1:0] median_doubled;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [PADDR_W-1:0]         paddr = '0;
	logic [PDATA_W-1:0]         pwdata = '0;
	logic [PDATA_W-1:0]         prdata;
	logic                       pready;

	// fixed expectation travelling with the request
	logic                       pin_row = 1'b0;
	logic                       pin_has = 1'b0;
	logic signed [MEDIAN_W-1:0] pin_res = '0;

	// predictor state
	logic signed [SAMPLE_W-1:0] arrival [WINDOW_MAX];
	logic signed [SAMPLE_W-1:0] ranked [WINDOW_MAX];
	int unsigned                held = 0;
	int unsigned                head = 0;
	logic [WSIZE_W-1:0]         win_len = 7'd3;

	logic signed [MEDIAN_W-1:0] median_due [$];
	int                         mismatch_count = 0;
	int                         idle_pct = 0;
	int                         stall_left = 0;

	sliding_window_median dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.median_doubled (median_doubled),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// one sample through the window, returns 1 when the window is full
	function automatic bit median_step(input logic signed [SAMPLE_W-1:0] s, input logic rs,
			output logic signed [MEDIAN_W-1:0] med);
		int unsigned k, slot, i;
		bit found;
		logic signed [MEDIAN_W-1:0] lo_x, hi_x;
		k = (win_len == 0) ? 1 : (win_len > WINDOW_MAX) ? WINDOW_MAX : win_len;
		med = '0;
		if (rs) begin
			held = 0;
			head = 0;
		end
		if (held >= k) begin
			slot = head % k;
			// drop exactly one copy of the leaving sample
			found = 1'b0;
			for (i = 0; i < held; i++) begin
				if (!found && ranked[i] == arrival[slot])
					found = 1'b1;
				if (found && i + 1 < held)
					ranked[i] = ranked[i + 1];
			end
			if (found)
				held--;
			arrival[slot] = s;
			head = (slot + 1) % k;
		end else begin
			arrival[(head + held) % k] = s;
		end
		// insertion keeps the store ascending
		i = held;
		while (i > 0 && ranked[i - 1] > s) begin
			ranked[i] = ranked[i - 1];
			i--;
		end
		ranked[i] = s;
		held++;
		if (held < k)
			return 1'b0;
		lo_x = (k % 2 == 1) ? ranked[k / 2] : ranked[k / 2 - 1];
		hi_x = ranked[k / 2];
		med = lo_x + hi_x;
		return 1'b1;
	endfunction

	// input acceptance feeds the predictor, output acceptance is checked
	always @(posedge clk) begin : monitor
		bit got;
		logic signed [MEDIAN_W-1:0] med;
		logic signed [MEDIAN_W-1:0] due;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				got = median_step(sample, restart, med);
				if (pin_row) begin
					if (pin_has)
						median_due = {median_due, pin_res};
				end else if (got) begin
					median_due = {median_due, med};
				end
			end
			if (out_valid && out_ready) begin
				if (median_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d", median_doubled));
				end else begin
					due = median_due.pop_front();
					if (median_doubled !== due)
						report_mismatch($sformatf("median_doubled %0d, want %0d",
							median_doubled, due));
				end
			end
		end
	end

	// result side back-pressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic rs,
			input logic pin, input logic has, input logic signed [MEDIAN_W-1:0] res);
		in_valid <= 1'b1;
		sample   <= s;
		restart  <= rs;
		pin_row  <= pin;
		pin_has  <= has;
		pin_res  <= res;
		do @(posedge clk); while (!in_ready);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// register write, or read with check against the shadow copy
	task automatic reg_access(input logic wr, input logic idx, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr && idx == REG_WINDOW_SIZE) begin
			win_len = data[WSIZE_W-1:0];
			held = 0;
			head = 0;
		end
		if (!wr && prdata !== PDATA_W'(win_len))
			report_mismatch($sformatf("window_size reads %0d, want %0d", prdata, win_len));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int v;
		v = $urandom_range(0, 8) - 4;
		case ($urandom_range(0, 9))
			0: return S_MIN;
			1: return S_MAX;
			2, 3, 4: return v;
			default: return $urandom;
		endcase
	endfunction

	// drain, reconfigure while idle, then a stream of random samples
	task automatic run_phase(input logic idx, input logic [WSIZE_W-1:0] len, input int n,
			input int pct);
		in_valid <= 1'b0;
		@(posedge clk);
		while (median_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		reg_access(1'b1, idx, {25'($urandom), len});
		reg_access(1'b0, REG_WINDOW_SIZE, '0);
		idle_pct = pct;
		repeat (n)
			send_sample(pick_sample(), $urandom_range(0, 39) == 0, 1'b0, 1'b0, '0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		reg_access(1'b0, REG_WINDOW_SIZE, '0);

		// opening sequence
		idle_pct = 20;
		foreach (OPENING[i])
			send_sample(OPENING[i].smp, OPENING[i].rs, OPENING[i].pinned,
				OPENING[i].has_res, OPENING[i].res);

		// window settings including zero and above the maximum
		run_phase(REG_WINDOW_SIZE, 7'd0, 60, 10);
		run_phase(REG_WINDOW_SIZE, 7'd1, 40, 0);
		run_phase(REG_WINDOW_SIZE, 7'd2, 80, 25);
		run_phase(REG_WINDOW_SIZE, 7'd64, 200, 10);
		run_phase(REG_WINDOW_SIZE, 7'd127, 150, 30);
		run_phase(REG_WINDOW_SIZE, 7'd4, 120, 5);
		run_phase(REG_WINDOW_SIZE, 7'd5, 100, 15);
		run_phase(REG_UNMAPPED, 7'd2, 60, 20);
		run_phase(REG_WINDOW_SIZE, 7'd16, 120, 10);
		run_phase(REG_WINDOW_SIZE, 7'($urandom_range(1, 127)), 200, 0);

		in_valid <= 1'b0;
		@(posedge clk);
		while (median_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_sliding_window_median passed");
		else
			$display("tb_sliding_window_median failed");
		$finish;
	end

	// hang guard
	initial begin
		#1_000_000;
		$display("tb_sliding_window_median failed");
		$finish;
	end

endmodule

// ===== sliding_window_median.f =====
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_median.sv
tb/tb_sliding_window_median.sv
